>>> rtl/srr_pkg.sv
// Shared types and constants of the selective repeat receiver.
package srr_pkg;

  // Payload words carried by one data packet.
  localparam int PAY_WORDS = 5;

  // Default number of reorder slots.
  localparam int DEF_WINDOW_SLOTS = 16;

  // Width and reset value of the window register.
  localparam int WIN_W = 5;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd16;

  // Width of a sequence number.
  localparam int SEQ_W = 31;

  // Result kinds.
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef logic [PAY_WORDS-1:0][31:0] payload_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq_number;
    logic signed [31:0] ack_number;
    logic signed [31:0] packet_checksum;
    logic [31:0]        payload_word0;
    logic [31:0]        payload_word1;
    logic [31:0]        payload_word2;
    logic [31:0]        payload_word3;
    logic [31:0]        payload_word4;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic [SEQ_W-1:0]   ack_seq;
    logic signed [31:0] ack_check;
    logic [31:0]        out_word0;
    logic [31:0]        out_word1;
    logic [31:0]        out_word2;
    logic [31:0]        out_word3;
    logic [31:0]        out_word4;
    logic               last_of_run;
  } out_word_t;

endpackage

>>> rtl/srr_slot_ram.sv
// Reorder slot payload memory: one write port, one read port with registered data.
module srr_slot_ram #(
  parameter int DEPTH  = srr_pkg::DEF_WINDOW_SLOTS,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  srr_pkg::payload_t wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output srr_pkg::payload_t rd_data
);

  srr_pkg::payload_t mem [DEPTH];
  srr_pkg::payload_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/selective_repeat_receiver.sv
// Selective repeat receiver: checks packets, acknowledges them and delivers payloads in order.
//
// Before its first result a packet word is accepted, its payload bytes are summed word by
// word, the checksum is finished against the ack and sequence numbers while the sequence
// number is compared with the expected one, and then the packet is decided and its payload
// stored in the reorder memory. The block takes one packet at a time and stalls its input
// until that packet's results have all been handed to the output register. When a stored run
// becomes deliverable, each delivery needs one read of the payload memory, whose read data
// is registered; the first read is issued after the acknowledgement and each further one is
// issued ahead while the previous word leaves. Valid bits of the slots live in flip-flops,
// so no clearing pass runs after reset. The window register may be written at any time the
// block is idle; values of zero act as one and values above the slot count act as the count.
module selective_repeat_receiver #(
  parameter int WINDOW_SLOTS = srr_pkg::DEF_WINDOW_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Packet input channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  srr_pkg::in_word_t          in_data,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output srr_pkg::out_word_t         out_data,
  // Window register write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [srr_pkg::WIN_W-1:0]  cfg_wdata
);

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [SLOT_W:0]   SLOTS_V   = (SLOT_W+1)'(WINDOW_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [8:0]        SLOTS_W9  = 9'(WINDOW_SLOTS);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_DLV  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  srr_pkg::in_word_t           pkt_r;
  logic [4:0][9:0]             wsum_r;
  logic                        ok_r;
  logic                        old_r;
  logic [srr_pkg::SEQ_W-1:0]   diff_r;
  logic [srr_pkg::SEQ_W-1:0]   expected_r, expected_nxt;
  logic [SLOT_W-1:0]           exp_slot_r, exp_slot_nxt;
  logic [WINDOW_SLOTS-1:0]     valid_r, valid_nxt;
  logic [srr_pkg::WIN_W-1:0]   window_r;
  logic                        out_valid_r, out_valid_nxt;
  srr_pkg::out_word_t          out_r, out_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic [4:0][9:0]             wsum;
  logic                        sum_ok;
  logic [8:0]                  win_eff;
  logic [SLOT_W:0]             slot_sum;
  logic [SLOT_W-1:0]           slot;
  logic [SLOT_W-1:0]           next_slot;
  logic                        more;
  logic                        ram_wr;
  logic                        ram_rd;
  logic [SLOT_W-1:0]           ram_rd_addr;
  srr_pkg::payload_t           ram_wdata;
  srr_pkg::payload_t           ram_rdata;
  srr_pkg::out_word_t          ack_word;
  srr_pkg::out_word_t          dlv_word;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Byte sums of each payload word, every byte taken as a signed value.
  always_comb begin
    logic [31:0] w;
    wsum = '0;
    for (int i = 0; i < srr_pkg::PAY_WORDS; i++) begin
      case (i)
        0:       w = pkt_r.payload_word0;
        1:       w = pkt_r.payload_word1;
        2:       w = pkt_r.payload_word2;
        3:       w = pkt_r.payload_word3;
        default: w = pkt_r.payload_word4;
      endcase
      wsum[i] = {{2{w[7]}}, w[7:0]} + {{2{w[15]}}, w[15:8]}
              + {{2{w[23]}}, w[23:16]} + {{2{w[31]}}, w[31:24]};
    end
  end

  // Finish the checksum: the five word sums plus the ack and sequence numbers.
  always_comb begin
    logic [31:0] total;
    total = pkt_r.ack_number + {1'b0, pkt_r.seq_number};
    for (int i = 0; i < srr_pkg::PAY_WORDS; i++) begin
      total = total + {{22{wsum_r[i][9]}}, wsum_r[i]};
    end
    sum_ok = (total == pkt_r.packet_checksum);
  end

  // Effective window, clamped to at least one and at most the slot count.
  always_comb begin
    if (window_r == '0) begin
      win_eff = 9'd1;
    end else if (9'(window_r) > SLOTS_W9) begin
      win_eff = SLOTS_W9;
    end else begin
      win_eff = 9'(window_r);
    end
  end

  // Slot of the packet: the distance from the expected number is below the slot count,
  // so one conditional subtract reduces it.
  assign slot_sum = {1'b0, exp_slot_r} + {1'b0, diff_r[SLOT_W-1:0]};
  assign slot     = (slot_sum >= SLOTS_V) ? SLOT_W'(slot_sum - SLOTS_V) : slot_sum[SLOT_W-1:0];

  // The expected slot follows the expected number, which wraps to zero at its top.
  assign next_slot = ((exp_slot_r == LAST_SLOT) || (expected_r == '1)) ?
                     '0 : exp_slot_r + SLOT_W'(1);
  assign more      = valid_r[next_slot] && (next_slot != exp_slot_r);

  assign ram_wdata = {pkt_r.payload_word4, pkt_r.payload_word3, pkt_r.payload_word2,
                      pkt_r.payload_word1, pkt_r.payload_word0};

  always_comb begin
    ack_word             = '0;
    ack_word.result_kind = srr_pkg::KIND_ACK;
    ack_word.ack_seq     = pkt_r.seq_number;
    ack_word.ack_check   = {1'b0, pkt_r.seq_number} + 32'd1;
    ack_word.last_of_run = 1'b1;
  end

  always_comb begin
    dlv_word             = '0;
    dlv_word.result_kind = srr_pkg::KIND_DATA;
    dlv_word.ack_seq     = expected_r;
    dlv_word.out_word0   = ram_rdata[0];
    dlv_word.out_word1   = ram_rdata[1];
    dlv_word.out_word2   = ram_rdata[2];
    dlv_word.out_word3   = ram_rdata[3];
    dlv_word.out_word4   = ram_rdata[4];
    dlv_word.last_of_run = !more;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    expected_nxt  = expected_r;
    exp_slot_nxt  = exp_slot_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_wr        = 1'b0;
    ram_rd        = 1'b0;
    ram_rd_addr   = exp_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (!ok_r) begin
          state_nxt = ST_IDLE;
        end else if (old_r) begin
          // Old packet: acknowledge again, nothing else.
          if (out_free) begin
            out_nxt       = ack_word;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (diff_r >= 31'(win_eff)) begin
          state_nxt = ST_IDLE;
        end else if (valid_r[slot]) begin
          // Duplicate: the stored payload stays, only the acknowledgement goes out.
          if (out_free) begin
            out_nxt       = ack_word;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (out_free) begin
          // New packet. Deliveries follow only if it fills the expected slot.
          out_nxt             = ack_word;
          out_nxt.last_of_run = (diff_r != '0);
          out_valid_nxt       = 1'b1;
          ram_wr              = 1'b1;
          valid_nxt[slot]     = 1'b1;
          state_nxt           = (diff_r == '0) ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        ram_rd    = 1'b1;
        state_nxt = ST_DLV;
      end
      ST_DLV: begin
        if (out_free) begin
          out_nxt                 = dlv_word;
          out_valid_nxt           = 1'b1;
          valid_nxt[exp_slot_r]   = 1'b0;
          expected_nxt            = expected_r + 31'd1;
          exp_slot_nxt            = next_slot;
          // Fetch the next payload while this one leaves.
          ram_rd                  = more;
          ram_rd_addr             = next_slot;
          state_nxt               = more ? ST_DLV : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      expected_r  <= '0;
      exp_slot_r  <= '0;
      valid_r     <= '0;
      window_r    <= srr_pkg::WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      exp_slot_r  <= exp_slot_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_wdata;
      end
    end
  end

  // Payload and per-packet working registers.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_acc) begin
      pkt_r <= in_data;
    end
    if (state_r == ST_SUM) begin
      wsum_r <= wsum;
    end
    if (state_r == ST_CHK) begin
      ok_r   <= sum_ok;
      old_r  <= (pkt_r.seq_number < expected_r);
      diff_r <= pkt_r.seq_number - expected_r;
    end
  end

  srr_slot_ram #(
    .DEPTH  (WINDOW_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (slot),
    .wr_data (ram_wdata),
    .rd_en   (ram_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

endmodule

>>> sim/selective_repeat_receiver_test.sv
// Self-checking testbench of the selective repeat receiver with its own predictor.
module selective_repeat_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = srr_pkg::DEF_WINDOW_SLOTS;
  localparam int SEQ_BITS = srr_pkg::SEQ_W;
  // Cycles to wait once nothing is expected: a dropped packet may still be in the pipe.
  localparam int DRAIN_CYCLES = 16;
  // Cycles without any handshake after which the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  // Length of the forced receiver hold-off in the back-pressure test.
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  srr_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  srr_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [srr_pkg::WIN_W-1:0] cfg_wdata;

  always #1 clk = ~clk;

  selective_repeat_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Receiver state as the testbench tracks it: the next in-order sequence
  // number, which reorder slots hold a payload, the payloads themselves and
  // the window register as last written.
  // ---------------------------------------------------------------------------
  logic [SEQ_BITS-1:0]       next_seq = '0;
  logic                      slot_held [SLOTS];
  srr_pkg::payload_t         slot_data [SLOTS];
  logic [srr_pkg::WIN_W-1:0] window_reg = srr_pkg::WINDOW_RESET;

  // Results that the accepted packets still owe, oldest first.
  srr_pkg::out_word_t results_due[$];

  int fail_count = 0;
  int burst_left = 0;
  int hold_request = 0;
  int idle_cycles = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_held[i] = 1'b0;
    end
  end

  // Appends one owed result behind the ones already waiting.
  function automatic void owe_result(srr_pkg::out_word_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  // Window as the block applies it: zero behaves as one, anything above the
  // slot count behaves as the slot count.
  function automatic int unsigned window_span();
    if (window_reg == 0) begin
      return 1;
    end
    return (window_reg > SLOTS) ? SLOTS : window_reg;
  endfunction

  // Wrapping sum of the twenty payload bytes, each sign extended, plus the
  // ack and sequence numbers.
  function automatic logic [31:0] packet_sum(srr_pkg::in_word_t p);
    logic [31:0] words [srr_pkg::PAY_WORDS];
    logic [31:0] s;
    logic [7:0]  b;
    words = '{p.payload_word0, p.payload_word1, p.payload_word2,
              p.payload_word3, p.payload_word4};
    s = {1'b0, p.seq_number} + p.ack_number;
    for (int w = 0; w < srr_pkg::PAY_WORDS; w++) begin
      for (int k = 0; k < 4; k++) begin
        b = words[w][8*k +: 8];
        s = s + {{24{b[7]}}, b};
      end
    end
    return s;
  endfunction

  function automatic srr_pkg::out_word_t ack_result(logic [SEQ_BITS-1:0] seq, logic last);
    srr_pkg::out_word_t r;
    r = '0;
    r.result_kind = srr_pkg::KIND_ACK;
    r.ack_seq     = seq;
    r.ack_check   = {1'b0, seq} + 32'd1;
    r.last_of_run = last;
    return r;
  endfunction

  // Works out the results of one accepted packet and updates the tracked state.
  function automatic void track_packet(srr_pkg::in_word_t p);
    logic [SEQ_BITS-1:0] seq;
    int unsigned         slot;
    int unsigned         here;
    srr_pkg::out_word_t  r;
    seq = p.seq_number;
    if (packet_sum(p) != p.packet_checksum) begin
      return;
    end
    // Old packets and duplicates are only acknowledged again.
    if (seq < next_seq) begin
      owe_result(ack_result(seq, 1'b1));
      return;
    end
    if (seq - next_seq >= window_span()) begin
      return;
    end
    slot = seq % SLOTS;
    if (slot_held[slot]) begin
      owe_result(ack_result(seq, 1'b1));
      return;
    end
    slot_held[slot] = 1'b1;
    slot_data[slot] = {p.payload_word4, p.payload_word3, p.payload_word2,
                       p.payload_word1, p.payload_word0};
    owe_result(ack_result(seq, !slot_held[next_seq % SLOTS]));
    // Deliver the run of stored payloads that now starts at next_seq.
    while (slot_held[next_seq % SLOTS]) begin
      here = next_seq % SLOTS;
      slot_held[here] = 1'b0;
      r = '0;
      r.result_kind = srr_pkg::KIND_DATA;
      r.ack_seq     = next_seq;
      r.out_word0   = slot_data[here][0];
      r.out_word1   = slot_data[here][1];
      r.out_word2   = slot_data[here][2];
      r.out_word3   = slot_data[here][3];
      r.out_word4   = slot_data[here][4];
      next_seq = next_seq + 1'b1;
      r.last_of_run = !slot_held[next_seq % SLOTS];
      owe_result(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Packet construction.
  // ---------------------------------------------------------------------------
  function automatic srr_pkg::in_word_t sealed(srr_pkg::in_word_t p);
    p.packet_checksum = packet_sum(p);
    return p;
  endfunction

  function automatic srr_pkg::in_word_t filled_packet(logic [SEQ_BITS-1:0] seq,
                                                      logic [31:0] ack,
                                                      logic [31:0] fill);
    srr_pkg::in_word_t p;
    p.seq_number    = seq;
    p.ack_number    = ack;
    p.payload_word0 = fill;
    p.payload_word1 = fill;
    p.payload_word2 = fill;
    p.payload_word3 = fill;
    p.payload_word4 = fill;
    return sealed(p);
  endfunction

  function automatic srr_pkg::in_word_t random_packet(logic [SEQ_BITS-1:0] seq);
    srr_pkg::in_word_t p;
    p.seq_number    = seq;
    p.ack_number    = $urandom;
    p.payload_word0 = $urandom;
    p.payload_word1 = $urandom;
    p.payload_word2 = $urandom;
    p.payload_word3 = $urandom;
    p.payload_word4 = $urandom;
    return sealed(p);
  endfunction

  function automatic srr_pkg::in_word_t corrupted(srr_pkg::in_word_t p);
    p.packet_checksum[5'($urandom_range(0, 31))] ^= 1'b1;
    return p;
  endfunction

  // Most packets land near the expected sequence number so that the reorder
  // slots fill, runs form and duplicates occur; the rest are stale packets,
  // damaged packets and sequence numbers drawn from the whole range.
  function automatic srr_pkg::in_word_t next_random_packet();
    int unsigned pick;
    int unsigned back;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return random_packet(SEQ_BITS'($urandom));
    end
    if (pick < 16) begin
      return corrupted(random_packet(SEQ_BITS'(next_seq + $urandom_range(0, window_span()))));
    end
    if (pick < 24 && next_seq != 0) begin
      back = (next_seq < 20) ? next_seq : 20;
      return random_packet(SEQ_BITS'(next_seq - $urandom_range(1, back)));
    end
    return random_packet(SEQ_BITS'(next_seq + $urandom_range(0, window_span() + 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge; a word is taken at the
  // rising edge where valid is high and the block does not stall. The sender
  // works in bursts with random gaps; a gap of zero merges two bursts.
  // ---------------------------------------------------------------------------
  task automatic send_packet(srr_pkg::in_word_t pkt);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= pkt;
    do @(posedge clk); while (in_stall);
    burst_left--;
    track_packet(pkt);
  endtask

  // Stops offering words and waits until every owed result has come out,
  // then lets a dropped packet still in the pipe run through.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The window register is only written while the block is idle.
  task automatic write_window(logic [srr_pkg::WIN_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    window_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. Stalls follow segments of random length: no stalls, light
  // stalls or heavy stalls. A hold-off request overrides the pattern and keeps
  // the output stalled for that many cycles, counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int seg_left;
    int seg_mode;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (seg_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  function automatic string show(srr_pkg::out_word_t r);
    return $sformatf("kind %0d seq %0d check %h words %h %h %h %h %h last %0d",
                     r.result_kind, r.ack_seq, r.ack_check, r.out_word0, r.out_word1,
                     r.out_word2, r.out_word3, r.out_word4, r.last_of_run);
  endfunction

  // Every word taken from the output is compared with the oldest owed result.
  always @(posedge clk) begin
    srr_pkg::out_word_t want;
    logic               bad;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected result: %s", show(out_data));
        end
      end else begin
        want = results_due.pop_front();
        bad = (out_data.result_kind !== want.result_kind) ||
              (out_data.ack_seq     !== want.ack_seq)     ||
              (out_data.ack_check   !== want.ack_check)   ||
              (out_data.out_word0   !== want.out_word0)   ||
              (out_data.out_word1   !== want.out_word1)   ||
              (out_data.out_word2   !== want.out_word2)   ||
              (out_data.out_word3   !== want.out_word3)   ||
              (out_data.out_word4   !== want.out_word4)   ||
              (out_data.last_of_run !== want.last_of_run);
        if (bad) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(out_data));
          end
        end
      end
    end
  end

  // Hang detection: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Byte extremes, a damaged checksum, a stale packet, packets past the
  // window (the largest sequence number and the first one just outside),
  // a packet on the window's last slot, its duplicate, and a gap that a late
  // packet closes. Runs with the window at its reset value.
  task automatic test_special_packets();
    send_packet(filled_packet('0, 32'h8000_0000, 32'h8080_8080));
    send_packet(corrupted(filled_packet(SEQ_BITS'(1), 32'h7fff_ffff, 32'h7f7f_7f7f)));
    send_packet(filled_packet('0, 32'hffff_ffff, 32'hffff_ffff));
    send_packet(filled_packet({SEQ_BITS{1'b1}}, 32'h0, 32'h0));
    send_packet(random_packet(SEQ_BITS'(next_seq + SLOTS)));
    send_packet(filled_packet(SEQ_BITS'(next_seq + SLOTS - 1), 32'h0, 32'h0));
    send_packet(random_packet(SEQ_BITS'(next_seq + SLOTS - 1)));
    send_packet(random_packet(SEQ_BITS'(next_seq + 1)));
    send_packet(random_packet(next_seq));
  endtask

  // Fills every slot out of order, then sends the missing head so that one
  // packet releases the longest possible run of deliveries.
  task automatic test_longest_run();
    logic [SEQ_BITS-1:0] head;
    head = next_seq;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      send_packet(random_packet(SEQ_BITS'(head + i)));
    end
    send_packet(random_packet(head));
  endtask

  // A window register of zero behaves as a window of one.
  task automatic test_window_zero();
    write_window('0);
    send_packet(random_packet(SEQ_BITS'(next_seq + 1)));
    send_packet(random_packet(next_seq));
  endtask

  // Random traffic under several window settings, the extremes among them.
  task automatic test_random_windows();
    logic [srr_pkg::WIN_W-1:0] windows [7];
    windows = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd0, 5'd12, 5'd3};
    foreach (windows[i]) begin
      write_window(windows[i]);
      repeat (40) send_packet(next_random_packet());
    end
  endtask

  // The receiver holds off for a long stretch while packets keep coming, so
  // the output backs up and the block stalls its input.
  task automatic test_backpressure();
    write_window(srr_pkg::WINDOW_RESET);
    hold_request = HOLD_CYCLES;
    repeat (40) send_packet(next_random_packet());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_special_packets();
    test_longest_run();
    test_window_zero();
    test_random_windows();
    test_backpressure();

    settle();
    fail_count += results_due.size();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
